[src/irtl_pkg.sv]
// Shared types and constants for the address range table lookup.
// Used by the front queue, the search engine and the top level.
package irtl_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	// Bounds of the search window run from 0 to TABLE_DEPTH inclusive.
	localparam int BND_W = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W = 96;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_MODE = 1'b1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_FIND = 1'b1;

	// Operation codes after classification by the front part.
	localparam logic [1:0] OP_SKIP = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_FIND = 2'd2;

	localparam logic [23:0] OFFSET_MASK = 24'hFF_FFFF;
	localparam logic [7:0] LEN_IN_DATA = 8'hFF;
	localparam logic [7:0] ID_BYTES = 8'd4;
	localparam int LEN_LSB = 24;

	typedef struct packed {
		logic [1:0] op;
		logic [IDX_W-1:0] idx;
		logic [31:0] key;    // range start for a load, query address for a lookup
		logic [31:0] rend;
		logic [31:0] word;
	} irtl_item_t;

	typedef struct packed {
		logic valid;
		irtl_item_t item;
	} irtl_head_t;

endpackage

[src/ip_range_table_lookup.sv]
// Top level of the address range table lookup: configuration registers, front queue and back engine.
// Depends on irtl_pkg, irtl_front, irtl_back and irtl_ram.
//
// A load request writes one table entry (start, end, packed word) when the search engine
// takes it from the queue; it produces no response. A lookup request binary-searches the first
// entry_count entries and produces one response. Each probe passes through the PROBE and CMP
// states, because the single read port of the table RAM has a registered output and the compare
// needs its data. A lookup makes at most ceil(log2(entry_count + 1)) probes, fewer on an early
// hit. A two-entry request queue lets new requests be taken while a lookup is under way, and
// the response register lets the next lookup start while a response waits. The table has no
// reset and needs no clearing pass; entries must be loaded before they are searched.
// Configuration writes are taken every cycle and must only be issued while the block is idle.
module ip_range_table_lookup (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [irtl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [irtl_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic                               command,
	input  logic [11:0]                        entry_index,
	input  logic [31:0]                        range_start,
	input  logic [31:0]                        range_end,
	input  logic [31:0]                        entry_word,
	input  logic [31:0]                        query_address,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic                               found,
	output logic [24:0]                        data_address,
	output logic [7:0]                         data_length,
	output logic                               length_in_data
);

	logic [irtl_pkg::CFG_DATA_W-1:0] entry_count_q;
	logic ext_mode_q;
	irtl_pkg::irtl_head_t head;
	logic pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			ext_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				irtl_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_data;
				irtl_pkg::REG_EXT_MODE: ext_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	irtl_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.command(command),
		.entry_index(entry_index),
		.range_start(range_start),
		.range_end(range_end),
		.entry_word(entry_word),
		.query_address(query_address),
		.head(head),
		.pop(pop)
	);

	irtl_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.entry_count(entry_count_q),
		.ext_mode(ext_mode_q),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.found(found),
		.data_address(data_address),
		.data_length(data_length),
		.length_in_data(length_in_data)
	);

endmodule

[src/irtl_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module irtl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/irtl_front.sv]
// Front part: takes requests, classifies them and holds them in a two-entry queue.
// Depends on irtl_pkg.
module irtl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                command,
	input  logic [11:0]         entry_index,
	input  logic [31:0]         range_start,
	input  logic [31:0]         range_end,
	input  logic [31:0]         entry_word,
	input  logic [31:0]         query_address,
	output irtl_pkg::irtl_head_t head,
	input  logic                pop
);

	irtl_pkg::irtl_item_t slot_q [2];
	irtl_pkg::irtl_item_t new_item;
	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push;
	logic       idx_ok;

	assign req_stall = (cnt_q == 2'd2);
	assign push = req_valid && !req_stall;

	// A load beyond the table is kept in the queue as a no-op so ordering stays intact.
	assign idx_ok = ({20'd0, entry_index} < 32'(irtl_pkg::TABLE_DEPTH));

	always_comb begin
		new_item.idx = irtl_pkg::IDX_W'(entry_index);
		new_item.rend = range_end;
		new_item.word = entry_word;
		if (command == irtl_pkg::CMD_FIND) begin
			new_item.op = irtl_pkg::OP_FIND;
			new_item.key = query_address;
		end else begin
			new_item.op = idx_ok ? irtl_pkg::OP_LOAD : irtl_pkg::OP_SKIP;
			new_item.key = range_start;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.item = slot_q[rd_ptr_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0) else $error("pop from an empty queue");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q)) else $error("queue pointers disagree");

endmodule

[src/irtl_back.sv]
// Back part: performs table loads and the binary search, and holds the result register.
// Depends on irtl_pkg and irtl_ram.
module irtl_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  irtl_pkg::irtl_head_t              head,
	output logic                              pop,
	input  logic [irtl_pkg::CFG_DATA_W-1:0]   entry_count,
	input  logic                              ext_mode,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic                              found,
	output logic [24:0]                       data_address,
	output logic [7:0]                        data_length,
	output logic                              length_in_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_CMP = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [irtl_pkg::BND_W-1:0] lo_q;
	logic [irtl_pkg::BND_W-1:0] hi_q;
	logic [irtl_pkg::BND_W-1:0] mid_q;
	logic [irtl_pkg::BND_W-1:0] mid;
	logic [irtl_pkg::BND_W-1:0] bound;
	logic [31:0] key_q;
	logic [31:0] word_q;
	logic ram_we;
	logic [irtl_pkg::ENTRY_W-1:0] rdata;
	logic [31:0] rd_start;
	logic [31:0] rd_end;
	logic [31:0] rd_word;
	logic out_valid_q;
	logic out_free;
	logic found_q;
	logic [24:0] addr_q;
	logic [7:0] len_q;
	logic in_data_q;
	logic [7:0] w_len;
	logic [24:0] w_off;
	logic [24:0] res_addr;
	logic [7:0] res_len;
	logic res_in_data;

	// A count above the table depth covers the whole table.
	assign bound = ({19'd0, entry_count} > 32'(irtl_pkg::TABLE_DEPTH))
		? irtl_pkg::BND_W'(irtl_pkg::TABLE_DEPTH)
		: irtl_pkg::BND_W'(entry_count);

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign pop = (state_q == ST_IDLE) && head.valid;
	assign ram_we = pop && (head.item.op == irtl_pkg::OP_LOAD);

	irtl_ram #(
		.WIDTH(irtl_pkg::ENTRY_W),
		.DEPTH(irtl_pkg::TABLE_DEPTH)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(head.item.idx),
		.wdata({head.item.key, head.item.rend, head.item.word}),
		.raddr(irtl_pkg::IDX_W'(mid)),
		.rdata(rdata)
	);

	assign rd_start = rdata[95:64];
	assign rd_end = rdata[63:32];
	assign rd_word = rdata[31:0];

	assign out_free = !out_valid_q || !rsp_stall;

	always_comb begin
		w_len = word_q[31:irtl_pkg::LEN_LSB];
		w_off = {1'b0, word_q[23:0] & irtl_pkg::OFFSET_MASK};
		res_addr = w_off;
		res_len = w_len;
		res_in_data = 1'b0;
		if (!ext_mode) begin
			if (w_len > irtl_pkg::ID_BYTES) begin
				res_len = w_len - irtl_pkg::ID_BYTES;
				res_addr = w_off + 25'(irtl_pkg::ID_BYTES);
			end
		end else if (w_len == irtl_pkg::LEN_IN_DATA) begin
			res_len = 8'd0;
			res_addr = w_off + 25'd2;
			res_in_data = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			key_q <= head.item.key;
		end
		if (state_q == ST_PROBE) begin
			mid_q <= mid;
			if (lo_q >= hi_q) begin
				word_q <= 32'd0;
			end
		end
		if (state_q == ST_CMP) begin
			word_q <= rd_word;
		end
		if (state_q == ST_DONE && out_free) begin
			if (word_q == 32'd0) begin
				found_q <= 1'b0;
				addr_q <= 25'd0;
				len_q <= 8'd0;
				in_data_q <= 1'b0;
			end else begin
				found_q <= 1'b1;
				addr_q <= res_addr;
				len_q <= res_len;
				in_data_q <= res_in_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lo_q <= '0;
			hi_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace one that is taken in the same cycle.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && head.item.op == irtl_pkg::OP_FIND) begin
						lo_q <= '0;
						hi_q <= bound;
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					// An empty window means a miss.
					state_q <= (lo_q < hi_q) ? ST_CMP : ST_DONE;
				end
				ST_CMP: begin
					if (key_q < rd_start) begin
						hi_q <= mid_q;
						state_q <= ST_PROBE;
					end else if (key_q > rd_end) begin
						lo_q <= mid_q + 1'b1;
						state_q <= ST_PROBE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign found = found_q;
	assign data_address = addr_q;
	assign data_length = len_q;
	assign length_in_data = in_data_q;

	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (lo_q <= hi_q)) else $error("search window inverted");
	a_mid_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (mid_q >= lo_q && mid_q < hi_q))
		else $error("probe outside the search window");
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the finish step");

endmodule

[test/ip_range_table_lookup_check.sv]
// Checker for the address range table lookup: watches the configuration, request and
// response channels, keeps its own copy of the range table and predicts each lookup.
// Depends on irtl_pkg for widths, command codes, register indexes and field constants.
module ip_range_table_lookup_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [irtl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [irtl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            req_valid,
	input  logic                            req_stall,
	input  logic                            command,
	input  logic [11:0]                     entry_index,
	input  logic [31:0]                     range_start,
	input  logic [31:0]                     range_end,
	input  logic [31:0]                     entry_word,
	input  logic [31:0]                     query_address,
	input  logic                            rsp_valid,
	input  logic                            rsp_stall,
	input  logic                            found,
	input  logic [24:0]                     data_address,
	input  logic [7:0]                      data_length,
	input  logic                            length_in_data,
	output int                              failures,
	output int                              pending,
	output int                              answered,
	output int                              hits
);

	// In extended mode the stored length occupies the first two data bytes.
	localparam logic [24:0] LEN_FIELD_BYTES = 25'd2;

	typedef struct packed {
		logic        found;
		logic [24:0] addr;
		logic [7:0]  len;
		logic        in_data;
	} answer_t;

	logic [31:0] start_mem [irtl_pkg::TABLE_DEPTH];
	logic [31:0] end_mem [irtl_pkg::TABLE_DEPTH];
	logic [31:0] word_mem [irtl_pkg::TABLE_DEPTH];
	logic [12:0] count_reg = '0;
	logic        ext_reg = 1'b0;
	answer_t     answer_q [$];
	int          fail_cnt = 0;
	int          answer_cnt = 0;
	int          hit_cnt = 0;

	function automatic answer_t search_table(input logic [31:0] key);
		answer_t    a;
		int         lo;
		int         hi;
		int         mid;
		logic [31:0] w;
		bit         hit;
		a = '0;
		w = '0;
		hit = 1'b0;
		lo = 0;
		hi = (count_reg > irtl_pkg::TABLE_DEPTH) ? irtl_pkg::TABLE_DEPTH : int'(count_reg);
		while (lo < hi && !hit) begin
			mid = lo + (hi - lo) / 2;
			if (key < start_mem[mid])
				hi = mid;
			else if (key > end_mem[mid])
				lo = mid + 1;
			else begin
				hit = 1'b1;
				w = word_mem[mid];
			end
		end
		if (w != '0) begin
			a.found = 1'b1;
			a.addr = {1'b0, w[23:0] & irtl_pkg::OFFSET_MASK};
			a.len = w[irtl_pkg::LEN_LSB +: 8];
			if (!ext_reg) begin
				// Plain mode: longer records start with an id that is skipped.
				if (a.len > irtl_pkg::ID_BYTES) begin
					a.len -= irtl_pkg::ID_BYTES;
					a.addr += irtl_pkg::ID_BYTES;
				end
			end else if (a.len == irtl_pkg::LEN_IN_DATA) begin
				a.len = '0;
				a.addr += LEN_FIELD_BYTES;
				a.in_data = 1'b1;
			end
		end
		return a;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_cnt++;
		$display("[%0t] lookup %0d: %s", $time, answer_cnt, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			count_reg = '0;
			ext_reg = 1'b0;
			answer_q.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (answer_q.size() == 0) begin
					report_mismatch("response arrived with no lookup outstanding");
				end else begin
					want = answer_q.pop_front();
					answer_cnt++;
					if (want.found)
						hit_cnt++;
					if (found !== want.found)
						report_mismatch($sformatf("found %b, expected %b", found, want.found));
					if (data_address !== want.addr)
						report_mismatch($sformatf("data_address %h, expected %h",
							data_address, want.addr));
					if (data_length !== want.len)
						report_mismatch($sformatf("data_length %0d, expected %0d",
							data_length, want.len));
					if (length_in_data !== want.in_data)
						report_mismatch($sformatf("length_in_data %b, expected %b",
							length_in_data, want.in_data));
				end
			end
			if (req_valid && !req_stall) begin
				if (command == irtl_pkg::CMD_LOAD) begin
					start_mem[entry_index] = range_start;
					end_mem[entry_index] = range_end;
					word_mem[entry_index] = entry_word;
				end else begin
					answer_q.push_back(search_table(query_address));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					irtl_pkg::REG_ENTRY_COUNT: count_reg = cfg_data;
					irtl_pkg::REG_EXT_MODE: ext_reg = cfg_data[0];
					default: ;
				endcase
			end
		end
		failures <= fail_cnt;
		pending <= answer_q.size();
		answered <= answer_cnt;
		hits <= hit_cnt;
	end

endmodule

[test/ip_range_table_lookup_test.sv]
// Top of the address range table lookup testbench: clock, reset, request and response
// traffic, configuration phases and the verdict. Depends on irtl_pkg, the block and
// ip_range_table_lookup_check, which predicts and compares every response.
module ip_range_table_lookup_test;

	localparam int LONG_HOLD = 400;
	localparam int SETTLE = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	// The initial fill covers both ends of the table and every sixteenth entry between.
	localparam int FILL_LOW = 256;
	localparam int FILL_HIGH = 3840;
	localparam int FILL_STRIDE = 16;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [irtl_pkg::CFG_IDX_W-1:0]  cfg_index = irtl_pkg::REG_ENTRY_COUNT;
	logic [irtl_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            req_valid = 1'b0;
	logic                            req_stall;
	logic                            command = irtl_pkg::CMD_LOAD;
	logic [11:0]                     entry_index = '0;
	logic [31:0]                     range_start = '0;
	logic [31:0]                     range_end = '0;
	logic [31:0]                     entry_word = '0;
	logic [31:0]                     query_address = '0;
	logic                            rsp_valid;
	logic                            rsp_stall = 1'b0;
	logic                            found;
	logic [24:0]                     data_address;
	logic [7:0]                      data_length;
	logic                            length_in_data;
	int                              failures;
	int                              pending;
	int                              answered;
	int                              hits;

	// Ranges last written per entry, so that lookups can be aimed at hits and edges.
	logic [31:0] slot_lo [irtl_pkg::TABLE_DEPTH];
	logic [31:0] slot_hi [irtl_pkg::TABLE_DEPTH];
	// Entries loaded at least once; a lookup is sent only if every probe lands on one.
	bit          written [irtl_pkg::TABLE_DEPTH];
	int          filled_list [$];
	int          span = 0;
	int          load_total = 0;
	int          setting_total = 0;
	int          calm_items = 0;
	int          req_idle_pct = 15;
	int          rsp_idle_pct = 8;
	bit          hold_off = 1'b0;

	ip_range_table_lookup dut (.*);
	ip_range_table_lookup_check lookup_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] rand_word();
		logic [7:0]  len;
		logic [23:0] off;
		case ($urandom_range(0, 7))
			0: len = 8'd0;
			1: len = irtl_pkg::ID_BYTES;
			2: len = irtl_pkg::ID_BYTES + 8'd1;
			3, 4: len = irtl_pkg::LEN_IN_DATA;
			default: len = 8'($urandom);
		endcase
		case ($urandom_range(0, 4))
			0: off = '0;
			1: off = irtl_pkg::OFFSET_MASK;
			default: off = 24'($urandom);
		endcase
		if ($urandom_range(0, 9) == 0)
			return '0;
		return {len, off};
	endfunction

	// Walks the probe sequence of the current window over the ranges loaded so far.
	function automatic bit lookup_safe(input logic [31:0] key);
		int lo;
		int hi;
		int mid;
		bit ok;
		ok = 1'b1;
		lo = 0;
		hi = span;
		while (lo < hi && ok) begin
			mid = lo + (hi - lo) / 2;
			if (!written[mid])
				ok = 1'b0;
			else if (key < slot_lo[mid])
				hi = mid;
			else if (key > slot_hi[mid])
				lo = mid + 1;
			else
				hi = lo;
		end
		return ok;
	endfunction

	task automatic offer(input logic cmd, input logic [11:0] idx, input logic [31:0] lo_a,
			input logic [31:0] hi_a, input logic [31:0] word, input logic [31:0] key);
		if (calm_items > 0) begin
			calm_items--;
		end else if (!hold_off && req_idle_pct != 0) begin
			if ($urandom_range(0, 39) == 0) begin
				calm_items = $urandom_range(10, 40);
			end else if ($urandom_range(1, 100) <= req_idle_pct) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
		req_valid <= 1'b1;
		command <= cmd;
		entry_index <= idx;
		range_start <= lo_a;
		range_end <= hi_a;
		entry_word <= word;
		query_address <= key;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic load_entry(input logic [11:0] idx, input logic [31:0] lo_a,
			input logic [31:0] hi_a, input logic [31:0] word);
		slot_lo[idx] = lo_a;
		slot_hi[idx] = hi_a;
		if (!written[idx]) begin
			written[idx] = 1'b1;
			filled_list.push_back(int'(idx));
		end
		load_total++;
		offer(irtl_pkg::CMD_LOAD, idx, lo_a, hi_a, word, $urandom);
	endtask

	// Rewrites an entry with a range inside its own slot, which keeps the table sorted.
	task automatic reload_slot(input logic [11:0] k);
		logic [19:0] s;
		logic [19:0] e;
		s = 20'($urandom);
		e = 20'($urandom_range(s, 20'hF_FFFF));
		load_entry(k, {k, s}, {k, e}, rand_word());
	endtask

	task automatic find(input logic [31:0] key);
		offer(irtl_pkg::CMD_FIND, 12'($urandom), $urandom, $urandom, $urandom, key);
	endtask

	// Loads give no response, so a settling pause follows the last lookup response.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(input logic [12:0] count, input logic mode);
		logic [11:0] pad;
		pad = 12'($urandom);
		cfg_valid <= 1'b1;
		cfg_index <= irtl_pkg::REG_ENTRY_COUNT;
		cfg_data <= count;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		// Upper bits of the mode write must be ignored.
		cfg_index <= irtl_pkg::REG_EXT_MODE;
		cfg_data <= {pad, mode};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		span = (count > irtl_pkg::TABLE_DEPTH) ? irtl_pkg::TABLE_DEPTH : int'(count);
		setting_total++;
	endtask

	task automatic run_phase(input logic [12:0] count, input logic mode, input int n,
			input bit squeeze);
		logic [11:0] k;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] key;
		int          i;
		int          j;
		int          pick;
		drain();
		configure(count, mode);
		if (squeeze)
			hold_off = 1'b1;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				if (span > 0 && $urandom_range(0, 1) == 0)
					k = 12'($urandom_range(0, span - 1));
				else
					k = 12'($urandom);
				// Mostly in-slot rewrites that keep the table sorted; some arbitrary ranges.
				if ($urandom_range(0, 9) == 0)
					load_entry(k, $urandom, $urandom, rand_word());
				else
					reload_slot(k);
			end else begin
				if (span == 0 || $urandom_range(0, 9) == 0) begin
					key = $urandom;
				end else begin
					if (span < irtl_pkg::TABLE_DEPTH && $urandom_range(0, 19) == 0) begin
						// Any loaded entry, often one beyond the searched window.
						pick = filled_list[$urandom_range(0, filled_list.size() - 1)];
					end else if (span <= FILL_LOW) begin
						pick = $urandom_range(0, span - 1);
					end else begin
						pick = filled_list[$urandom_range(0, filled_list.size() - 1)];
						for (j = 0; j < 16 && pick >= span; j++)
							pick = filled_list[$urandom_range(0, filled_list.size() - 1)];
					end
					lo = slot_lo[pick];
					hi = slot_hi[pick];
					case ($urandom_range(0, 5))
						0: key = lo;
						1: key = hi;
						2: key = lo - 32'd1;
						3: key = hi + 32'd1;
						default: key = $urandom_range(lo, hi);
					endcase
				end
				// A lookup that would probe a never-loaded entry turns into a rewrite.
				if (lookup_safe(key))
					find(key);
				else
					reload_slot(12'($urandom));
			end
		end
	endtask

	initial begin
		logic [11:0] k;
		logic [19:0] s;
		logic [19:0] e;
		int          i;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset the entry count is zero, so every lookup misses.
		find('0);
		find('1);

		// Sorted ranges, one per 1M slot: both ends of the table in full and every
		// sixteenth entry between them, which covers the upper levels of every search.
		for (i = 0; i < irtl_pkg::TABLE_DEPTH; i++) begin
			if (i < FILL_LOW || i >= FILL_HIGH || i % FILL_STRIDE == 0) begin
				k = 12'(i);
				s = (i == 0) ? 20'h0_0000 : 20'($urandom);
				e = (i == irtl_pkg::TABLE_DEPTH - 1) ? 20'hF_FFFF
					: 20'($urandom_range(s, 20'hF_FFFF));
				load_entry(k, {k, s}, {k, e}, rand_word());
			end
		end

		drain();
		configure(13'd5, 1'b0);
		load_entry(12'd0, '0, {12'd0, 20'hF_FF00}, {irtl_pkg::ID_BYTES, 24'h00_0000});
		load_entry(12'd1, {12'd1, 20'h0_0100}, {12'd1, 20'hF_FF00},
			{irtl_pkg::ID_BYTES + 8'd1, 24'h12_3456});
		load_entry(12'd2, {12'd2, 20'h0_0100}, {12'd2, 20'hF_FF00},
			{irtl_pkg::LEN_IN_DATA, irtl_pkg::OFFSET_MASK});
		load_entry(12'd3, {12'd3, 20'h0_0100}, {12'd3, 20'hF_FF00}, '0);
		load_entry(12'd4, {12'd4, 20'h0_0100}, {12'd4, 20'hF_FF00}, {8'd0, 24'h00_0001});
		find('0);
		find({12'd1, 20'h0_0100});
		find({12'd2, 20'hF_FF00});
		find({12'd3, 20'h8_0000});
		find({12'd4, 20'hF_FF00});
		find({12'd4, 20'hF_FF01});
		find({12'd5, 20'h8_0000});

		drain();
		configure(13'd5, 1'b1);
		find({12'd2, 20'h8_0000});
		find({12'd1, 20'h0_0100});

		// A count past the table depth searches the whole table.
		drain();
		configure(13'h1FFF, 1'b1);
		find('1);
		find('0);
		// Entry 1024 overlapping everything lies on the probe path of a lookup in entry 2000.
		load_entry(12'd1024, '0, '1, {8'd9, 24'h00_ABCD});
		find(slot_lo[2000]);
		load_entry(12'd1024, {12'd1024, 20'h0_0100}, {12'd1024, 20'hF_FF00}, rand_word());

		run_phase(13'd4096, 1'b0, 100, 1'b1);
		run_phase(13'd1, 1'b1, 100, 1'b0);
		run_phase(13'd2, 1'b0, 100, 1'b0);
		run_phase(13'($urandom_range(3, FILL_LOW)), 1'b1, 100, 1'b0);
		run_phase(13'd0, 1'b0, 80, 1'b0);
		run_phase(13'($urandom_range(4097, 8191)), 1'b0, 100, 1'b0);
		run_phase(13'h1FFF, 1'b1, 100, 1'b0);
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		run_phase(13'd4096, 1'b1, 110, 1'b0);
		drain();

		$display("Ran %0d table loads and %0d checked lookups (%0d hits) over %0d settings,",
			load_total, answered, hits, setting_total);
		$display("from empty to saturated entry counts in plain and extended length modes.");
		if (failures == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Response side: random stall bursts, calm stretches, and one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 1'b0;
				hold_off = 1'b0;
			end else if (rsp_idle_pct != 0 && $urandom_range(1, 100) <= rsp_idle_pct) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if ($urandom_range(0, 99) == 0) begin
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no request, response or register write moved for %0d cycles.",
			WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[ip_range_table_lookup.f]
src/irtl_pkg.sv
src/irtl_ram.sv
src/irtl_front.sv
src/irtl_back.sv
src/ip_range_table_lookup.sv
test/ip_range_table_lookup_check.sv
test/ip_range_table_lookup_test.sv
